>>> sv/set_assoc_lru_writeback_cache_defines.svh
// set_assoc_lru_writeback_cache_defines.svh
// assertion macros shared by the top level and salwc_lookup; expects clk and rst_n in scope
`ifndef SET_ASSOC_LRU_WRITEBACK_CACHE_DEFINES_SVH
`define SET_ASSOC_LRU_WRITEBACK_CACHE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SALWC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SALWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/salwc_pkg.sv
// salwc_pkg.sv
// shared types, constants and helpers for the set-associative cache
// no dependencies
`timescale 1ns / 1ps

package salwc_pkg;

    // default build sizes
    localparam int unsigned DEF_MAX_SETS  = 256;
    localparam int unsigned DEF_MAX_WAYS  = 8;
    localparam int unsigned DEF_ADDR_BITS = 32;

    // fixed field widths
    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned TAG_W     = 32;
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned WAY_OUT_W = 3;
    localparam int unsigned CFG_W     = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned AGE_W     = 3;
    // set index before reduction: up to 15 bits from a 4-bit width register
    localparam int unsigned IDX_W     = 15;

    localparam logic [AGE_W-1:0] AGE_TOP = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE    = 2'd2;

    // configuration reset values
    localparam logic [CFG_W-1:0] RST_OFFSET_BITS    = 4'd5;
    localparam logic [CFG_W-1:0] RST_SET_INDEX_BITS = 4'd6;
    localparam logic [CFG_W-1:0] RST_WAYS_IN_USE    = 4'd4;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
        logic                 writeback;
        logic [TAG_W-1:0]     victim_tag;
        logic [CNT_W-1:0]     read_count;
        logic [CNT_W-1:0]     read_miss_count;
        logic [CNT_W-1:0]     write_count;
        logic [CNT_W-1:0]     write_miss_count;
        logic [CNT_W-1:0]     writeback_count;
    } rsp_t;

    // per-way line state kept in the metadata memory
    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [AGE_W-1:0] age;
    } way_meta_t;

    // status of the way scan
    typedef struct packed {
        logic done;
        logic hit;
        logic placed;
    } lookup_t;

    // saturating age increment
    function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
        logic [AGE_W-1:0] r;
        r = (a == AGE_TOP) ? a : a + 1'b1;
        return r;
    endfunction

endpackage

>>> sv/set_assoc_lru_writeback_cache.sv
// set_assoc_lru_writeback_cache.sv - top level of a tag-only set-associative cache
// with LRU replacement, write-back and write-allocate; uses salwc_pkg,
// salwc_store, salwc_lookup and the assertion macros header.
// Channels: cfg (valid/ready, index and 4-bit data) writes offset_bits,
// set_index_bits and ways_in_use; cfg is always ready; the user must write it only when
// idle, which the block itself does not enforce. in (valid/ready) carries one request:
// action and byte address. out (valid/ready) carries one result per request: hit, way,
// writeback, victim tag and the running counts after that request.
// Flow: a request goes through the set read, a way search in the shared comparator (up to
// ways_in_use ways, fewer on an early hit), the pick-up of the scan result and the set
// update that loads the result. The result becomes valid as the sequencer returns to
// idle, so the next request can be taken in that same cycle. When MAX_SETS is not a
// power of two the set index is reduced first by a reciprocal multiply, a subtract back
// and one correcting subtract.
// Reset: all counts clear, configuration returns to 5/6/4, and the metadata
// memory is swept clean set by set, during which in_ready stays low.
// Stall: the result waits in the output register; a finished request whose result
// cannot be loaded holds before touching the set until out_ready frees the register.
`timescale 1ns / 1ps
`include "set_assoc_lru_writeback_cache_defines.svh"

module set_assoc_lru_writeback_cache import salwc_pkg::*; #(
    parameter int unsigned MAX_SETS  = DEF_MAX_SETS,
    parameter int unsigned MAX_WAYS  = DEF_MAX_WAYS,
    parameter int unsigned ADDR_BITS = DEF_ADDR_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  req_t                 in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rsp_t                 out_data
);

    localparam int unsigned SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int unsigned K_W   = 2;
    localparam bit SETS_POW2 = ((MAX_SETS & (MAX_SETS - 1)) == 0);
    // reduction steps: quotient estimate, subtract back, final correction
    localparam logic [K_W-1:0]    K_QUOT   = 2'd2;
    localparam logic [K_W-1:0]    K_SUB    = 2'd1;
    localparam logic [K_W-1:0]    K_FIX    = 2'd0;
    localparam logic [IDX_W-1:0]  SET_MASK = IDX_W'(MAX_SETS - 1);
    localparam logic [IDX_W:0]    SET_DIV  = (IDX_W + 1)'(MAX_SETS);
    localparam logic [IDX_W-1:0]  SET_DIV_N = IDX_W'(MAX_SETS);
    // reciprocal of the set count scaled by 2^RECIP_SH; estimate is low by at most one
    localparam int unsigned       RECIP_SH  = IDX_W + SET_W;
    localparam logic [IDX_W:0]    SET_RECIP = (IDX_W + 1)'((64'd1 << RECIP_SH)
                                                           / 64'(MAX_SETS));
    localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}}
                                            : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REDUCE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;

    logic [CFG_W-1:0]   offset_reg;
    logic [CFG_W-1:0]   set_bits_reg;
    logic [CFG_W-1:0]   ways_reg;

    logic               action_reg;
    logic               action_next;
    logic [TAG_W-1:0]   tag_reg;
    logic [TAG_W-1:0]   tag_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [K_W-1:0]     k_reg;
    logic [K_W-1:0]     k_next;
    logic [IDX_W-1:0]   quot_reg;
    logic [IDX_W-1:0]   quot_next;

    logic [CNT_W-1:0]   reads_reg;
    logic [CNT_W-1:0]   read_miss_reg;
    logic [CNT_W-1:0]   writes_reg;
    logic [CNT_W-1:0]   write_miss_reg;
    logic [CNT_W-1:0]   wbacks_reg;
    logic [CNT_W-1:0]   reads_next;
    logic [CNT_W-1:0]   read_miss_next;
    logic [CNT_W-1:0]   writes_next;
    logic [CNT_W-1:0]   write_miss_next;
    logic [CNT_W-1:0]   wbacks_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    rsp_t               out_data_reg;
    rsp_t               rsp_next;

    logic [ADDR_W-1:0]  addr_m;
    logic [ADDR_W-1:0]  addr_sh;
    logic [IDX_W-1:0]   idx_mask;
    logic [IDX_W-1:0]   idx_raw;
    logic [CFG_W:0]     tag_shamt;
    logic [TAG_W-1:0]   tag_in;
    logic [2*IDX_W:0]   red_prod;
    logic [IDX_W-1:0]   red_quot;
    logic [IDX_W-1:0]   red_back;

    logic [CFG_W:0]     ways_c;
    logic [WAY_W-1:0]   last_way;
    logic [SET_W-1:0]   set_addr;

    logic                           clr_busy;
    logic [MAX_WAYS-1:0][TAG_W-1:0] rd_tags;
    way_meta_t [MAX_WAYS-1:0]       rd_meta;
    logic [MAX_WAYS-1:0][TAG_W-1:0] new_tags;
    way_meta_t [MAX_WAYS-1:0]       new_meta;
    lookup_t                        lk_flags;
    logic [WAY_W-1:0]               lk_way;
    way_meta_t                      sel_meta;
    logic                           wback;
    logic [WAY_W+WAY_OUT_W-1:0]     way_ext;

    logic               accept;
    logic               commit;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= RST_OFFSET_BITS;
            set_bits_reg <= RST_SET_INDEX_BITS;
            ways_reg     <= RST_WAYS_IN_USE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_OFFSET_BITS:    offset_reg   <= cfg_data;
                CFG_SET_INDEX_BITS: set_bits_reg <= cfg_data;
                CFG_WAYS_IN_USE:    ways_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    // associativity in use, clamped to 1 .. MAX_WAYS
    always_comb
    begin
        if (ways_reg == '0)
        begin
            ways_c = (CFG_W + 1)'(1);
        end
        else if ({1'b0, ways_reg} > (CFG_W + 1)'(MAX_WAYS))
        begin
            ways_c = (CFG_W + 1)'(MAX_WAYS);
        end
        else
        begin
            ways_c = {1'b0, ways_reg};
        end
    end

    assign last_way = WAY_W'(ways_c - 1'b1);

    // address split into set index and tag
    assign addr_m    = in_data.address & ADDR_MASK;
    assign addr_sh   = addr_m >> offset_reg;
    assign idx_mask  = IDX_W'((16'd1 << set_bits_reg) - 16'd1);
    assign idx_raw   = addr_sh[IDX_W-1:0] & idx_mask;
    assign tag_shamt = {1'b0, offset_reg} + {1'b0, set_bits_reg};
    assign tag_in    = addr_m >> tag_shamt;

    // set index remainder: reciprocal multiply, subtract back, one correcting subtract
    assign red_prod = (2*IDX_W + 1)'(idx_reg) * (2*IDX_W + 1)'(SET_RECIP);
    assign red_quot = IDX_W'(red_prod >> RECIP_SH);
    assign red_back = quot_reg * SET_DIV_N;
    assign set_addr = idx_reg[SET_W-1:0];

    assign in_ready = (state_reg == S_IDLE) && !clr_busy;
    assign accept   = in_valid && in_ready;
    assign commit   = (state_reg == S_UPDATE) && (!out_valid_reg || out_ready);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        action_next = action_reg;
        tag_next    = tag_reg;
        idx_next    = idx_reg;
        k_next      = k_reg;
        quot_next   = quot_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    action_next = in_data.action;
                    tag_next    = tag_in;
                    k_next      = K_QUOT;
                    if (SETS_POW2)
                    begin
                        idx_next   = idx_raw & SET_MASK;
                        state_next = S_READ;
                    end
                    else
                    begin
                        idx_next   = idx_raw;
                        state_next = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                if (k_reg == K_QUOT)
                begin
                    quot_next = red_quot;
                end
                else if (k_reg == K_SUB)
                begin
                    idx_next = idx_reg - red_back;
                end
                else if ({1'b0, idx_reg} >= SET_DIV)
                begin
                    idx_next = IDX_W'({1'b0, idx_reg} - SET_DIV);
                end
                if (k_reg == K_FIX)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    k_next = k_reg - 1'b1;
                end
            end
            S_READ:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (lk_flags.done)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // set update: ages, dirty and valid bits, tag fill
    assign sel_meta = rd_meta[lk_way];
    assign wback    = !lk_flags.hit && !lk_flags.placed && sel_meta.valid && sel_meta.dirty;

    always_comb
    begin
        new_meta = rd_meta;
        new_tags = rd_tags;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (WAY_W'(i) != lk_way && WAY_W'(i) <= last_way && rd_meta[i].valid
                && (!sel_meta.valid || rd_meta[i].age <= sel_meta.age))
            begin
                new_meta[i].age = age_inc(rd_meta[i].age);
            end
        end
        new_meta[lk_way].age = '0;
        if (lk_flags.hit)
        begin
            new_meta[lk_way].dirty = sel_meta.dirty || action_reg;
        end
        else
        begin
            new_meta[lk_way].valid = 1'b1;
            new_meta[lk_way].dirty = action_reg;
            new_tags[lk_way]       = tag_reg;
        end
    end

    // running counts
    always_comb
    begin
        reads_next      = reads_reg;
        read_miss_next  = read_miss_reg;
        writes_next     = writes_reg;
        write_miss_next = write_miss_reg;
        wbacks_next     = wbacks_reg;
        if (action_reg)
        begin
            writes_next = writes_reg + 1'b1;
            if (!lk_flags.hit)
            begin
                write_miss_next = write_miss_reg + 1'b1;
            end
        end
        else
        begin
            reads_next = reads_reg + 1'b1;
            if (!lk_flags.hit)
            begin
                read_miss_next = read_miss_reg + 1'b1;
            end
        end
        if (wback)
        begin
            wbacks_next = wbacks_reg + 1'b1;
        end
    end

    // result assembly
    assign way_ext = {{WAY_OUT_W{1'b0}}, lk_way};

    always_comb
    begin
        rsp_next.hit              = lk_flags.hit;
        rsp_next.way              = way_ext[WAY_OUT_W-1:0];
        rsp_next.writeback        = wback;
        rsp_next.victim_tag       = wback ? rd_tags[lk_way] : '0;
        rsp_next.read_count       = reads_next;
        rsp_next.read_miss_count  = read_miss_next;
        rsp_next.write_count      = writes_next;
        rsp_next.write_miss_count = write_miss_next;
        rsp_next.writeback_count  = wbacks_next;
    end

    // output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            reads_reg      <= '0;
            read_miss_reg  <= '0;
            writes_reg     <= '0;
            write_miss_reg <= '0;
            wbacks_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                reads_reg      <= reads_next;
                read_miss_reg  <= read_miss_next;
                writes_reg     <= writes_next;
                write_miss_reg <= write_miss_next;
                wbacks_reg     <= wbacks_next;
            end
        end
    end

    // request payload and result
    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        tag_reg    <= tag_next;
        idx_reg    <= idx_next;
        k_reg      <= k_next;
        quot_reg   <= quot_next;
        if (commit)
        begin
            out_data_reg <= rsp_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // set memories
    salwc_store #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (state_reg == S_READ),
        .rd_addr  (set_addr),
        .wr_en    (commit),
        .wr_addr  (set_addr),
        .wr_tags  (new_tags),
        .wr_meta  (new_meta),
        .rd_tags  (rd_tags),
        .rd_meta  (rd_meta),
        .clr_busy (clr_busy)
    );

    // way scan
    salwc_lookup #(
        .MAX_WAYS (MAX_WAYS)
    ) u_lookup (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_READ),
        .tag      (tag_reg),
        .tags     (rd_tags),
        .meta     (rd_meta),
        .last_way (last_way),
        .flags    (lk_flags),
        .way      (lk_way)
    );

    // checks
    `SALWC_ASSERT_SAME(a_result_from_update, $rose(out_valid_reg),
        $past(state_reg) == S_UPDATE, "result appeared without a set update")
    `SALWC_ASSERT_NEXT(a_commit_loads_result, commit,
        out_valid_reg && state_reg == S_IDLE, "committed request left no result")
    `SALWC_ASSERT_SAME(a_no_writeback_on_hit, out_valid_reg && out_data_reg.hit,
        !out_data_reg.writeback && out_data_reg.victim_tag == '0,
        "hit reported together with an eviction")
    `SALWC_ASSERT_SAME(a_no_request_while_clearing, state_reg != S_IDLE, !clr_busy,
        "request in flight during the clearing pass")

endmodule

>>> sv/salwc_store.sv
// salwc_store.sv
// tag and metadata memories, one row per set, with a clearing pass after reset
// depends on salwc_pkg
`timescale 1ns / 1ps

module salwc_store import salwc_pkg::*; #(
    parameter int unsigned MAX_SETS = DEF_MAX_SETS,
    parameter int unsigned MAX_WAYS = DEF_MAX_WAYS,
    localparam int unsigned SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               rd_en,
    input  logic [SET_W-1:0]                   rd_addr,
    input  logic                               wr_en,
    input  logic [SET_W-1:0]                   wr_addr,
    input  logic [MAX_WAYS-1:0][TAG_W-1:0]     wr_tags,
    input  way_meta_t [MAX_WAYS-1:0]           wr_meta,
    output logic [MAX_WAYS-1:0][TAG_W-1:0]     rd_tags,
    output way_meta_t [MAX_WAYS-1:0]           rd_meta,
    output logic                               clr_busy
);

    localparam logic [SET_W-1:0] LAST_SET = SET_W'(MAX_SETS - 1);

    logic [MAX_WAYS-1:0][TAG_W-1:0] tag_mem [MAX_SETS];
    way_meta_t [MAX_WAYS-1:0]       meta_mem [MAX_SETS];

    logic [MAX_WAYS-1:0][TAG_W-1:0] rd_tags_reg;
    way_meta_t [MAX_WAYS-1:0]       rd_meta_reg;

    logic                           clr_busy_reg;
    logic                           clr_busy_next;
    logic [SET_W-1:0]               clr_addr_reg;
    logic [SET_W-1:0]               clr_addr_next;

    logic                           meta_we;
    logic [SET_W-1:0]               meta_addr;
    way_meta_t [MAX_WAYS-1:0]       meta_wdata;

    // clearing pass over the metadata, one set per cycle
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            if (clr_addr_reg == LAST_SET)
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // metadata write port shared between clearing and line updates
    assign meta_we    = clr_busy_reg || wr_en;
    assign meta_addr  = clr_busy_reg ? clr_addr_reg : wr_addr;
    assign meta_wdata = clr_busy_reg ? '0 : wr_meta;

    // tag memory, no reset contents
    always_ff @(posedge clk)
    begin
        if (wr_en && !clr_busy_reg)
        begin
            tag_mem[wr_addr] <= wr_tags;
        end
        if (rd_en)
        begin
            rd_tags_reg <= tag_mem[rd_addr];
        end
    end

    // metadata memory
    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_addr] <= meta_wdata;
        end
        if (rd_en)
        begin
            rd_meta_reg <= meta_mem[rd_addr];
        end
    end

    assign rd_tags  = rd_tags_reg;
    assign rd_meta  = rd_meta_reg;
    assign clr_busy = clr_busy_reg;

endmodule

>>> sv/salwc_lookup.sv
// salwc_lookup.sv
// way scan: one shared tag and age comparator stepped over the ways of a set
// depends on salwc_pkg and the assertion macros header
`timescale 1ns / 1ps
`include "set_assoc_lru_writeback_cache_defines.svh"

module salwc_lookup import salwc_pkg::*; #(
    parameter int unsigned MAX_WAYS = DEF_MAX_WAYS,
    localparam int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [TAG_W-1:0]               tag,
    input  logic [MAX_WAYS-1:0][TAG_W-1:0] tags,
    input  way_meta_t [MAX_WAYS-1:0]       meta,
    input  logic [WAY_W-1:0]               last_way,
    output lookup_t                        flags,
    output logic [WAY_W-1:0]               way
);

    logic             busy_reg;
    logic             busy_next;
    logic [WAY_W-1:0] cnt_reg;
    logic [WAY_W-1:0] cnt_next;
    logic             inv_found_reg;
    logic             inv_found_next;
    logic [WAY_W-1:0] inv_way_reg;
    logic [WAY_W-1:0] inv_way_next;
    logic [AGE_W-1:0] best_age_reg;
    logic [AGE_W-1:0] best_age_next;
    logic [WAY_W-1:0] oldest_reg;
    logic [WAY_W-1:0] oldest_next;
    lookup_t          flags_reg;
    lookup_t          flags_next;
    logic [WAY_W-1:0] way_reg;
    logic [WAY_W-1:0] way_next;

    way_meta_t        cur;
    logic             match;

    // the shared compare unit looks at one way per cycle
    assign cur   = meta[cnt_reg];
    assign match = cur.valid && (tags[cnt_reg] == tag);

    always_comb
    begin
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        inv_found_next = inv_found_reg;
        inv_way_next   = inv_way_reg;
        best_age_next  = best_age_reg;
        oldest_next    = oldest_reg;
        flags_next     = flags_reg;
        flags_next.done = 1'b0;
        way_next       = way_reg;

        if (start)
        begin
            busy_next      = 1'b1;
            cnt_next       = '0;
            inv_found_next = 1'b0;
            flags_next     = '0;
        end
        else if (busy_reg)
        begin
            // lowest invalid way
            if (!cur.valid && !inv_found_reg)
            begin
                inv_found_next = 1'b1;
                inv_way_next   = cnt_reg;
            end
            // oldest way, lowest on ties
            if (cnt_reg == '0 || cur.age > best_age_reg)
            begin
                best_age_next = cur.age;
                oldest_next   = cnt_reg;
            end

            if (match)
            begin
                busy_next         = 1'b0;
                flags_next.done   = 1'b1;
                flags_next.hit    = 1'b1;
                flags_next.placed = 1'b0;
                way_next          = cnt_reg;
            end
            else if (cnt_reg == last_way)
            begin
                busy_next         = 1'b0;
                flags_next.done   = 1'b1;
                flags_next.hit    = 1'b0;
                flags_next.placed = inv_found_next;
                way_next          = inv_found_next ? inv_way_next : oldest_next;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            inv_found_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            inv_found_reg <= inv_found_next;
            flags_reg     <= flags_next;
        end
    end

    // scan payload
    always_ff @(posedge clk)
    begin
        inv_way_reg  <= inv_way_next;
        best_age_reg <= best_age_next;
        oldest_reg   <= oldest_next;
        way_reg      <= way_next;
    end

    assign flags = flags_reg;
    assign way   = way_reg;

    // checks
    `SALWC_ASSERT_SAME(a_done_ends_scan, flags_reg.done, !busy_reg,
        "scan reported done while still busy")
    `SALWC_ASSERT_SAME(a_result_consistent, flags_reg.done,
        !(flags_reg.hit && flags_reg.placed) && way_reg <= last_way,
        "scan result names a hit and a fill or a way out of use")

endmodule
